[hw/rtl/cpr_pkg.sv]
// cpr_pkg: shared types and constants for the clock page replacement unit.
// Used by cpr_ctrl, cpr_datapath and clock_page_replacement_unit.
// No dependencies.
package cpr_pkg;

  // Default number of table slots
  localparam int CPR_SLOTS = 64;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 6;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 16;

  // Operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_INSTALL   = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_REFERENCE = 2'd2,
    OP_VICTIM    = 2'd3
  } op_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic               valid;
    logic               refb;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch the input word, zero the result
    logic clear;       // write one zero entry of the reset pass
    logic access;      // install/remove write, or reference read
    logic ref_wb;      // reference write-back
    logic sweep_init;  // start a victim sweep at the hand
    logic sweep;       // one sweep cycle
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last slot
    op_t  op;          // latched operation
    logic sweep_hit;   // victim found this cycle
    logic sweep_end;   // both passes done, no victim
  } dp_sts_t;

endpackage

[hw/rtl/cpr_ctrl.sv]
// cpr_ctrl: controller state machine of the clock page replacement unit.
// Depends on cpr_pkg; drives cpr_datapath through dp_cmd_t.
module cpr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cpr_pkg::dp_sts_t sts,
  output cpr_pkg::dp_cmd_t cmd,
  output logic            busy,
  output logic            done
);
  import cpr_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ACCESS = 6'b000100,
    ST_REFWB  = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (sts.op == OP_VICTIM) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end else if (sts.op == OP_REFERENCE) begin
          cmd.access = 1'b1;
          state_next = ST_REFWB;
        end else begin
          cmd.access = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_REFWB: begin
        cmd.ref_wb = 1'b1;
        state_next = ST_RESULT;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_hit || sts.sweep_end) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESULT);

endmodule

[hw/rtl/cpr_datapath.sv]
// cpr_datapath: slot memory, clock hand, sweep counters and result registers.
// Depends on cpr_pkg; commanded by cpr_ctrl.
module cpr_datapath #(
  parameter int SLOTS = cpr_pkg::CPR_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cpr_pkg::dp_cmd_t            cmd,
  output cpr_pkg::dp_sts_t            sts,
  input  logic [cpr_pkg::OP_W-1:0]    op,
  input  logic [cpr_pkg::SLOT_W-1:0]  slot,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_id,
  input  logic [cpr_pkg::FRAME_W-1:0] frame_number,
  output logic                        found,
  output logic [cpr_pkg::FRAME_W-1:0] victim_frame,
  output logic [cpr_pkg::PAGE_W-1:0]  victim_page,
  output logic [cpr_pkg::SLOT_W-1:0]  victim_slot
);
  import cpr_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  // Slot memory: one write port, one registered read port
  entry_t mem [SLOTS];
  entry_t rd;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;

  // Latched input word
  op_t                op_q;
  logic [IW-1:0]      slot_q;
  logic               slot_ok;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;
  logic [IW+SLOT_W-1:0] slot_ext;

  // Clearing pass, hand and sweep state
  logic [IW-1:0] clr_cnt;
  logic [IW-1:0] hand;
  logic [IW-1:0] scan;
  logic          pass;
  logic          stop;
  logic          live;
  logic [IW-1:0] scan_q;
  logic          pass_q;
  logic          issue;
  logic          eval;
  logic          hit;
  logic          clr_ref;
  logic [IW+SLOT_W-1:0] vic_ext;

  assign slot_ext = (IW + SLOT_W)'(slot);
  assign vic_ext  = (IW + SLOT_W)'(scan_q);

  // Sweep decisions on the word read last cycle
  assign issue   = cmd.sweep && !stop;
  assign eval    = cmd.sweep && live;
  assign hit     = eval && rd.valid && !rd.refb;
  assign clr_ref = eval && rd.valid && rd.refb;

  assign sts.clear_last = (clr_cnt == LAST);
  assign sts.op         = op_q;
  assign sts.sweep_hit  = hit;
  assign sts.sweep_end  = eval && !hit && pass_q && (scan_q == LAST);

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = '0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (cmd.access && slot_ok && op_q == OP_INSTALL) begin
      we    = 1'b1;
      wdata = '{valid: 1'b1, refb: 1'b1, page: page_q, frame: frame_q};
    end else if (cmd.access && slot_ok && op_q == OP_REMOVE) begin
      we    = 1'b1;
      wdata = '{valid: 1'b0, refb: 1'b0, page: page_q, frame: frame_q};
    end else if (cmd.ref_wb && slot_ok && rd.valid) begin
      we    = 1'b1;
      wdata = '{valid: 1'b1, refb: 1'b1, page: rd.page, frame: rd.frame};
    end else if (clr_ref) begin
      we    = 1'b1;
      waddr = scan_q;
      wdata = '{valid: 1'b1, refb: 1'b0, page: rd.page, frame: rd.frame};
    end
  end

  assign raddr = cmd.access ? slot_q : scan;

  // Memory access
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // Input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(op);
      slot_q  <= slot_ext[IW-1:0];
      slot_ok <= (32'(slot) < 32'(SLOTS));
      page_q  <= page_id;
      frame_q <= frame_number;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= (clr_cnt == LAST) ? '0 : clr_cnt + 1'b1;
    end
  end

  // Sweep address counter: first pass from the hand, second from slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      scan   <= '0;
      pass   <= 1'b0;
      stop   <= 1'b0;
      live   <= 1'b0;
      scan_q <= '0;
      pass_q <= 1'b0;
    end else if (cmd.sweep_init) begin
      scan <= hand;
      pass <= 1'b0;
      stop <= 1'b0;
      live <= 1'b0;
    end else if (cmd.sweep) begin
      live <= issue;
      if (issue) begin
        scan_q <= scan;
        pass_q <= pass;
        if (scan == LAST) begin
          scan <= '0;
          if (pass) stop <= 1'b1;
          else pass <= 1'b1;
        end else begin
          scan <= scan + 1'b1;
        end
      end
    end
  end

  // Clock hand
  always_ff @(posedge clk) begin
    if (rst) begin
      hand <= '0;
    end else if (hit) begin
      hand <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
    end else if (sts.sweep_end) begin
      hand <= '0;
    end
  end

  // Result registers; zero for everything but a found victim
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found        <= 1'b0;
      victim_frame <= '0;
      victim_page  <= '0;
      victim_slot  <= '0;
    end else if (hit) begin
      found        <= 1'b1;
      victim_frame <= rd.frame;
      victim_page  <= rd.page;
      victim_slot  <= vic_ext[SLOT_W-1:0];
    end
  end

endmodule

[hw/rtl/clock_page_replacement_unit.sv]
// clock_page_replacement_unit: top level of the clock (second-chance) victim selector.
// Depends on cpr_pkg, cpr_ctrl and cpr_datapath.
//
// Channel  | Handshake              | Word
// ---------+------------------------+------------------------------------------
// input    | start & !busy          | op, slot, page_id, frame_number
// result   | done (one cycle)       | found, victim_frame, victim_page, victim_slot
//
// Install and remove pass through the access and result states from accept to done;
// reference adds a write-back state between them. A victim request sweeps from the
// hand: the sweep reads one slot per cycle from the slot memory's single read port, at most two passes.
// After reset a clearing pass writes every slot, with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module clock_page_replacement_unit #(
  parameter int SLOTS = cpr_pkg::CPR_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cpr_pkg::OP_W-1:0]    op,
  input  logic [cpr_pkg::SLOT_W-1:0]  slot,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_id,
  input  logic [cpr_pkg::FRAME_W-1:0] frame_number,
  output logic                        done,
  output logic                        found,
  output logic [cpr_pkg::FRAME_W-1:0] victim_frame,
  output logic [cpr_pkg::PAGE_W-1:0]  victim_page,
  output logic [cpr_pkg::SLOT_W-1:0]  victim_slot
);
  import cpr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cpr_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .slot         (slot),
    .page_id      (page_id),
    .frame_number (frame_number),
    .found        (found),
    .victim_frame (victim_frame),
    .victim_page  (victim_page),
    .victim_slot  (victim_slot)
  );

endmodule
